FILE: design/ios_pkg.sv
// ----------------------------------------------------------------------------
// ios_pkg
// shared types and constants of the operand stack
// ----------------------------------------------------------------------------
package ios_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int DEPTH_W         = 5;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        BIPUSH = 2'd0,
        IADD   = 2'd1,
        ISUB   = 2'd2,
        IMUL   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

FILE: design/ijvm_operand_stack_top.sv
// ----------------------------------------------------------------------------
// ijvm_operand_stack_top
// operand stack of a small stack machine: push immediate, add, sub, mul
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                           | tuser
//  s_axis   | in  | immediate[31:0]                 | kind[1:0]
//  m_axis   | out | top_word[31:0], depth[36:32]    | status[1:0]
//
//  each transaction is accepted with a stack memory read, then executed once any held result is taken
//  the word directly below top is read from the stack ram; the top word is cached
//  one result transaction per input transaction, in order
//  reset clears the word count and output valid; stack ram needs no clearing
//  a stalled result holds; the next input is taken while it waits
// ----------------------------------------------------------------------------
module ijvm_operand_stack_top #(
    parameter int STACK_DEPTH = ios_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // immediate[31:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // top_word[31:0], stack_depth[36:32], zero
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import ios_pkg::*;

    cmd_t                cmd;
    logic [WORD_W-1:0]   top_word;
    logic [DEPTH_W-1:0]  stack_depth;

    ios_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    ios_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_kind         (s_axis_tuser),
        .in_immediate    (s_axis_tdata),
        .out_top_word    (top_word),
        .out_stack_depth (stack_depth),
        .out_status      (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, stack_depth, top_word};

endmodule

FILE: design/ios_ram.sv
// ----------------------------------------------------------------------------
// ios_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ios_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ios_ctrl.sv
// ----------------------------------------------------------------------------
// ios_ctrl
// controller: input handshake, execute sequencing and output valid
// ----------------------------------------------------------------------------
module ios_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ios_pkg::cmd_t cmd
);

    import ios_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // load only from idle, and always followed by execute
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("load not followed by execute");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while held");

endmodule

FILE: design/ios_dp.sv
// ----------------------------------------------------------------------------
// ios_dp
// datapath: stack memory, cached top word, word count, alu and result register
// ----------------------------------------------------------------------------
module ios_dp #(
    parameter int STACK_DEPTH = ios_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ios_pkg::cmd_t                   cmd,
    input  logic [ios_pkg::KIND_W-1:0]      in_kind,
    input  logic [ios_pkg::WORD_W-1:0]      in_immediate,
    output logic [ios_pkg::WORD_W-1:0]      out_top_word,
    output logic [ios_pkg::DEPTH_W-1:0]     out_stack_depth,
    output logic [ios_pkg::STATUS_W-1:0]    out_status
);

    import ios_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    op_t                op_reg;
    logic [WORD_W-1:0]  imm_reg;
    logic [WORD_W-1:0]  top_reg, top_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [WORD_W-1:0]  out_top_reg, out_top_next;
    logic [DEPTH_W-1:0] out_depth_reg;
    status_t            out_status_reg, status_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  below;
    logic [WORD_W-1:0]  alu_result;
    logic               full;
    logic               few;

    ios_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (AW'(count_reg - CW'(2))),
        .rdata (below)
    );

    assign full = (count_reg >= CW'(STACK_DEPTH));
    assign few  = (count_reg < CW'(2));

    always_comb
    begin
        case (op_reg)
            IADD:    alu_result = below + top_reg;
            ISUB:    alu_result = below - top_reg;
            IMUL:    alu_result = below * top_reg;
            default: alu_result = below + top_reg;
        endcase
    end

    always_comb
    begin
        top_next    = top_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        ram_waddr   = AW'(count_reg);
        ram_wdata   = imm_reg;
        if (op_reg == BIPUSH)
        begin
            if (full)
            begin
                status_next = STAT_OVERFLOW;
            end
            else
            begin
                ram_we     = cmd.exec;
                top_next   = imm_reg;
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (few)
            begin
                status_next = STAT_UNDERFLOW;
            end
            else
            begin
                ram_we     = cmd.exec;
                ram_waddr  = AW'(count_reg - CW'(2));
                ram_wdata  = alu_result;
                top_next   = alu_result;
                count_next = count_reg - CW'(1);
            end
        end
        out_top_next = (count_next == '0) ? '0 : top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_kind);
            imm_reg <= in_immediate;
        end
        if (cmd.exec)
        begin
            top_reg        <= top_next;
            out_top_reg    <= out_top_next;
            out_depth_reg  <= DEPTH_W'(count_next);
            out_status_reg <= status_next;
        end
    end

    assign out_top_word    = out_top_reg;
    assign out_stack_depth = out_depth_reg;
    assign out_status      = out_status_reg;

    // word count stays within capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("word count beyond capacity");

    // the count is untouched except by execute
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("word count changed without execute");

endmodule

FILE: tb/ios_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ios_stack_checker
// watches both stream channels of the operand stack, keeps its own copy of
// the stack to predict each result and compares every result transaction
// field by field against the oldest prediction
// ----------------------------------------------------------------------------
module ios_stack_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // immediate[31:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // top_word[31:0], stack_depth[36:32], zero
    input  logic [1:0]  m_axis_tuser,   // status[1:0]
    output int          fail_count,
    output int          results_pending
);

    import ios_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]  top_word;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } stack_result_t;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH_DEF];
    int                word_total;
    stack_result_t     expected_results [$];

    task report_mismatch(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic stack_result_t apply_instr(op_t op, logic [WORD_W-1:0] imm);
        logic [WORD_W-1:0] top_w;
        logic [WORD_W-1:0] below_w;
        logic [WORD_W-1:0] sum_w;
        stack_result_t     res;
        res.status = STAT_OK;
        if (op == BIPUSH)
        begin
            if (word_total >= STACK_DEPTH_DEF)
                res.status = STAT_OVERFLOW;
            else
            begin
                stack_mem[word_total] = imm;
                word_total++;
            end
        end
        else if (word_total < 2)
            res.status = STAT_UNDERFLOW;
        else
        begin
            top_w   = stack_mem[word_total-1];
            below_w = stack_mem[word_total-2];
            case (op)
                IADD:    sum_w = below_w + top_w;
                ISUB:    sum_w = below_w - top_w;
                default: sum_w = below_w * top_w;
            endcase
            word_total--;
            stack_mem[word_total-1] = sum_w;
        end
        res.top_word = (word_total == 0) ? '0 : stack_mem[word_total-1];
        res.depth    = DEPTH_W'(word_total);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            word_total = 0;
            expected_results.delete();
            results_pending <= 0;
        end
        else
        begin
            // results always leave later than their instruction is accepted, so pop first
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.top_word)
                        report_mismatch("top_word", m_axis_tdata[31:0], want.top_word);
                    if (m_axis_tdata[36:32] !== want.depth)
                        report_mismatch("stack_depth", m_axis_tdata[36:32], want.depth);
                    if (m_axis_tdata[39:37] !== 3'b000)
                        report_mismatch("tdata padding", m_axis_tdata[39:37], 3'b000);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_instr(op_t'(s_axis_tuser), s_axis_tdata));
            results_pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives instruction transactions into the operand stack with random gaps and
// random result back-pressure, including long receiver hold-offs that fill the
// block; a directed opening covers underflow, overflow and wrapping arithmetic,
// then biased fill and drain phases walk the stack between empty and full
// ----------------------------------------------------------------------------
module testbench;
    import ios_pkg::*;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int results_pending;
    bit hold_active = 1'b0;
    int send_burst  = 0;
    int recv_burst  = 0;

    always #6 clk = ~clk;

    ijvm_operand_stack_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ios_stack_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // idle cycles before the next transaction, with occasional stretches of none
    task automatic pick_wait(inout int burst_left, output int unsigned cycles);
        if (burst_left > 0)
        begin
            burst_left--;
            cycles = 0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            cycles     = 0;
        end
        else
            cycles = $urandom_range(0, 15);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5:    return 32'($urandom_range(0, 15));
            6:       return -32'($urandom_range(1, 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_instr(input op_t op, input logic [31:0] imm);
        int unsigned gap;
        pick_wait(send_burst, gap);
        if (hold_active)
            gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= imm;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int  n;
        int  seg_left;
        bit  filling;
        op_t op;
        seg_left = 0;
        filling  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // arithmetic on an empty stack and on a single word
        send_instr(IADD, rand_word());
        send_instr(ISUB, rand_word());
        send_instr(IMUL, rand_word());
        send_instr(BIPUSH, 32'h8000_0000);
        send_instr(IMUL, rand_word());
        // add, sub and mul at the extremes; the mul wraps
        send_instr(BIPUSH, 32'h7FFF_FFFF);
        send_instr(IADD, rand_word());
        send_instr(BIPUSH, 32'h7FFF_FFFF);
        send_instr(ISUB, rand_word());
        send_instr(BIPUSH, 32'hFFFF_FFFF);
        send_instr(IMUL, rand_word());
        // fill up, then push into a full stack
        for (n = 0; n < STACK_DEPTH_DEF - 1; n++)
            send_instr(BIPUSH, rand_word());
        send_instr(BIPUSH, 32'h7FFF_FFFF);

        // alternating fill and drain phases
        for (n = 0; n < 1350; n++)
        begin
            if (seg_left == 0)
            begin
                filling  = !filling;
                seg_left = $urandom_range(15, 50);
            end
            seg_left--;
            if ($urandom_range(0, 99) < (filling ? 70 : 25))
                op = BIPUSH;
            else
                op = op_t'($urandom_range(1, 3));
            send_instr(op, rand_word());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        int          result_idx;
        int          hold_cnt;
        result_idx = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (result_idx == 150 || result_idx == 900)
            begin
                // long hold-off so the block backs up and stalls its input
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 300; hold_cnt++)
                    @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                pick_wait(recv_burst, stall);
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            result_idx++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
